@@ src/assert_macros.svh @@
// Assertion macros shared by the byte engine RTL.
// Each macro wraps one clocked concurrent assertion on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, including during reset.
`define ASSERT_ALW(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/i2cm_pkg.sv @@
// Package for the I2C master byte engine: operation codes, engine states,
// word structs and phase constants. No dependencies.
package i2cm_pkg;

  localparam logic [2:0] OP_CODE_START = 3'd0;
  localparam logic [2:0] OP_CODE_STOP  = 3'd1;
  localparam logic [2:0] OP_CODE_WRITE = 3'd2;
  localparam logic [2:0] OP_CODE_READ  = 3'd3;
  localparam logic [2:0] OP_CODE_WAIT  = 3'd4;

  localparam logic [4:0]  BIT_PHASES     = 5'd16;
  localparam logic [4:0]  READ_ACK_PHASE = 5'd17;
  localparam logic [15:0] HALF_RESET     = 16'd250;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_START = 6'b000010,
    ST_STOP  = 6'b000100,
    ST_WRITE = 6'b001000,
    ST_READ  = 6'b010000,
    ST_WAIT  = 6'b100000
  } op_state_t;

  typedef struct packed {
    logic drv;
    logic sda;
    logic scl;
  } line_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] operation;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_missing;
  } out_item_t;

  function automatic op_state_t decode_op(input logic [2:0] code);
    op_state_t st;
    case (code)
      OP_CODE_START: st = ST_START;
      OP_CODE_STOP:  st = ST_STOP;
      OP_CODE_WRITE: st = ST_WRITE;
      OP_CODE_READ:  st = ST_READ;
      OP_CODE_WAIT:  st = ST_WAIT;
      default:       st = ST_IDLE;
    endcase
    return st;
  endfunction

  function automatic logic [4:0] phase_count(input op_state_t st);
    logic [4:0] n;
    case (st)
      ST_START: n = 5'd3;
      ST_STOP:  n = 5'd3;
      ST_WRITE: n = BIT_PHASES + 5'd1;
      ST_READ:  n = BIT_PHASES + 5'd3;
      ST_WAIT:  n = 5'd4;
      default:  n = 5'd1;
    endcase
    return n;
  endfunction

endpackage

@@ src/i2cm_if.sv @@
// Channel interfaces for the I2C master byte engine: one for input words,
// one for result words. Both use a valid/ready handshake.
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [2:0] operation;
  logic [7:0] write_data;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, cmd_valid, operation, write_data, send_ack, sda_in,
                  input ready);
  modport sink   (input valid, cmd_valid, operation, write_data, send_ack, sda_in,
                  output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       ack_missing;

  modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  read_byte, ack_missing, input ready);
  modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  read_byte, ack_missing, output ready);
endinterface

@@ src/i2c_master_byte_engine.sv @@
// Top level of the I2C master byte engine: input word register, phase
// sequencer (i2cm_engine) and result word register. Uses i2cm_pkg, i2cm_if.
//
// Usage:
//   Each input word on in_bus stands for one tick of the bus timing. It
//   carries an optional command (cmd_valid, operation, write_data, send_ack)
//   and the sampled SDA level. Every accepted word yields exactly one result
//   word on out_bus with the SCL/SDA levels for that tick, busy, done and,
//   on the done tick, read_byte or ack_missing.
//   cfg_we/cfg_wdata write the half period in ticks (reset 250, 0 acts as 1);
//   write it only while no command is running.
//   A result passes through the input register and then the result register.
//   Throughput is one word per cycle while out_bus moves: the input register
//   and the result register each take a new word whenever the stage after
//   them moves, and the sequencer does one tick of work between them.
//   When the receiver stalls, the result register holds its word and the
//   input register fills; in_bus.ready then drops until out_bus moves again.
//   Synchronous reset empties both registers, idles the engine with SCL
//   high and SDA released, and restores the half period to 250.
`include "assert_macros.svh"

module i2c_master_byte_engine
  import i2cm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  i2cm_in_if.sink      in_bus,
  i2cm_out_if.source   out_bus
);

  logic      s1_v_r;
  in_item_t  s1_r;
  logic      out_v_r;
  out_item_t out_r;
  out_item_t res;
  logic      advance;
  logic      in_take;
  logic      step_en;

  assign advance      = !out_v_r || out_bus.ready;
  assign in_bus.ready = !s1_v_r || advance;
  assign in_take      = in_bus.valid && in_bus.ready;
  assign step_en      = s1_v_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_take) begin
      s1_v_r <= 1'b1;
    end else if (advance) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r.cmd_valid  <= in_bus.cmd_valid;
      s1_r.operation  <= in_bus.operation;
      s1_r.write_data <= in_bus.write_data;
      s1_r.send_ack   <= in_bus.send_ack;
      s1_r.sda_in     <= in_bus.sda_in;
    end
  end

  i2cm_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step_en   (step_en),
    .item      (s1_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_r <= res;
    end
  end

  assign out_bus.valid       = out_v_r;
  assign out_bus.scl_level   = out_r.scl_level;
  assign out_bus.sda_level   = out_r.sda_level;
  assign out_bus.sda_drive   = out_r.sda_drive;
  assign out_bus.busy_res    = out_r.busy_res;
  assign out_bus.done_res    = out_r.done_res;
  assign out_bus.read_byte   = out_r.read_byte;
  assign out_bus.ack_missing = out_r.ack_missing;

  `ASSERT_RST(a_stalled_word_kept, (s1_v_r && !advance) |=> s1_v_r, "input word lost while the result side stalls")
  `ASSERT_RST(a_step_fills_out, step_en |=> out_v_r, "engine step without a result word")
  `ASSERT_RST(a_done_has_busy, (out_v_r && out_r.done_res) |-> out_r.busy_res, "done word without busy")

endmodule

@@ src/i2cm_engine.sv @@
// Phase sequencer of the I2C master: command state, phase and tick counters,
// shift byte and line levels, advanced one tick per step. Uses i2cm_pkg.
`include "assert_macros.svh"

module i2cm_engine
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        step_en,
  input  in_item_t    item,
  output out_item_t   res
);

  op_state_t   op_r, op_nxt;
  logic [4:0]  phase_r, phase_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        ack_r, ack_nxt;
  line_t       lines_r, lines_nxt;
  logic [15:0] half_r;

  function automatic line_t mk_line(input logic scl, input logic sda, input logic drv);
    line_t l;
    l.scl = scl;
    l.sda = sda;
    l.drv = drv;
    return l;
  endfunction

  function automatic line_t enter_phase(input op_state_t st, input logic [4:0] p,
                                        input logic [7:0] sh, input logic ack,
                                        input line_t cur);
    line_t l;
    l = cur;
    case (st)
      ST_START: begin
        if (p == 5'd0) l = mk_line(1'b1, 1'b1, 1'b1);
        else if (p == 5'd1) l = mk_line(1'b1, 1'b0, 1'b1);
        else l = mk_line(1'b0, 1'b0, 1'b1);
      end
      ST_STOP: begin
        if (p == 5'd0) l = mk_line(1'b0, 1'b0, 1'b1);
        else if (p == 5'd1) l = mk_line(1'b1, 1'b0, 1'b1);
        else l = mk_line(1'b1, 1'b1, 1'b1);
      end
      ST_WRITE: begin
        if (p < BIT_PHASES && !p[0]) l = mk_line(1'b0, sh[7], 1'b1);
        else if (p < BIT_PHASES) l = mk_line(1'b1, cur.sda, 1'b1);
        else l = mk_line(1'b0, cur.sda, 1'b1);
      end
      ST_READ: begin
        if (p < BIT_PHASES) l = mk_line(p[0], 1'b1, 1'b0);
        else l = mk_line(p == READ_ACK_PHASE, !ack, 1'b1);
      end
      ST_WAIT: begin
        if (p == 5'd0) l = mk_line(1'b1, 1'b1, 1'b0);
        else if (p == 5'd1) l = mk_line(1'b0, 1'b0, 1'b1);
        else if (p == 5'd2) l = mk_line(1'b1, 1'b0, 1'b1);
        else l = mk_line(1'b1, 1'b1, 1'b1);
      end
      default: l = cur;
    endcase
    return l;
  endfunction

  line_t       lines_ld;
  logic        busy;
  logic        fin;
  logic [15:0] half_eff;
  logic [4:0]  ph_inc;

  always_comb begin
    op_nxt    = op_r;
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    shift_nxt = shift_r;
    ack_nxt   = ack_r;
    lines_ld  = lines_r;
    fin       = 1'b0;
    ph_inc    = phase_r + 5'd1;
    half_eff  = (half_r == 16'd0) ? 16'd1 : half_r;
    res       = '0;

    if (op_r == ST_IDLE && item.cmd_valid && item.operation <= OP_CODE_WAIT) begin
      op_nxt    = decode_op(item.operation);
      phase_nxt = 5'd0;
      tick_nxt  = 16'd0;
      if (op_nxt == ST_WRITE) shift_nxt = item.write_data;
      if (op_nxt == ST_READ) begin
        shift_nxt = 8'd0;
        ack_nxt   = item.send_ack;
      end
      if (op_nxt == ST_WAIT) ack_nxt = 1'b0;
      lines_ld = enter_phase(op_nxt, 5'd0, shift_nxt, ack_nxt, lines_r);
    end

    busy      = (op_nxt != ST_IDLE);
    lines_nxt = lines_ld;

    if (busy) begin
      tick_nxt = tick_nxt + 16'd1;
      if (tick_nxt >= half_eff) begin
        tick_nxt = 16'd0;
        if ((op_nxt == ST_READ || op_nxt == ST_WRITE) && phase_nxt < BIT_PHASES &&
            phase_nxt[0]) begin
          shift_nxt = {shift_nxt[6:0], (op_nxt == ST_READ) ? item.sda_in : 1'b0};
        end
        if (op_nxt == ST_WAIT && phase_nxt == 5'd0) begin
          if (!item.sda_in) begin
            fin       = 1'b1;
            lines_nxt = mk_line(1'b0, 1'b1, 1'b0);
          end else begin
            ack_nxt = 1'b1;
          end
        end
        if (!fin) begin
          ph_inc    = phase_nxt + 5'd1;
          phase_nxt = ph_inc;
          if (ph_inc >= phase_count(op_nxt)) begin
            fin = 1'b1;
            if (op_nxt == ST_READ || op_nxt == ST_WAIT) lines_nxt = mk_line(1'b0, 1'b1, 1'b1);
          end else begin
            lines_nxt = enter_phase(op_nxt, ph_inc, shift_nxt, ack_nxt, lines_ld);
          end
        end
        if (fin) begin
          res.done_res = 1'b1;
          if (op_nxt == ST_READ) res.read_byte = shift_nxt;
          if (op_nxt == ST_WAIT) res.ack_missing = ack_nxt;
          op_nxt    = ST_IDLE;
          phase_nxt = 5'd0;
        end
      end
    end

    res.scl_level = lines_ld.scl;
    res.sda_level = lines_ld.sda;
    res.sda_drive = lines_ld.drv;
    res.busy_res  = busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= HALF_RESET;
    end else if (cfg_we) begin
      half_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r    <= ST_IDLE;
      phase_r <= 5'd0;
      tick_r  <= 16'd0;
      shift_r <= 8'd0;
      ack_r   <= 1'b0;
      lines_r <= mk_line(1'b1, 1'b1, 1'b0);
    end else if (step_en) begin
      op_r    <= op_nxt;
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      shift_r <= shift_nxt;
      ack_r   <= ack_nxt;
      lines_r <= lines_nxt;
    end
  end

  `ASSERT_ALW(a_idle_counters_clear, (op_r == ST_IDLE) |-> (phase_r == 5'd0 && tick_r == 16'd0), "idle engine with nonzero phase or tick count")
  `ASSERT_RST(a_done_goes_idle, (step_en && res.done_res) |=> (op_r == ST_IDLE), "engine not idle after a done word")
  `ASSERT_RST(a_phase_in_range, phase_r < phase_count(ST_READ), "phase step beyond the longest command")

endmodule

@@ sim/i2cm_line_checker.sv @@
// Checker for the I2C master byte engine: keeps its own copy of the bus phase
// sequencer, advances it by one tick per accepted input word and compares every
// result word with it. Depends on i2cm_pkg and the channel interfaces.
module i2cm_line_checker
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  i2cm_in_if          in_mon,
  i2cm_out_if         out_mon,
  output int          fail_count,
  output int          pending,
  output int          started,
  output logic        engine_busy,
  output int          words_checked,
  output int          cmds_done,
  output int          reads_done,
  output int          nack_stops
);

  op_state_t   op_now;
  logic [4:0]  step_no;
  logic [15:0] tick_no;
  logic [7:0]  shreg;
  logic        ack_flag;
  line_t       lines;
  logic [15:0] half_cfg;
  out_item_t   line_words_due[$];
  int          errs = 0;
  int          starts = 0;
  int          checked = 0;
  int          dones = 0;
  int          reads = 0;
  int          nacks = 0;

  function automatic line_t lv(input logic scl, input logic sda, input logic drv);
    line_t l;
    l.scl = scl;
    l.sda = sda;
    l.drv = drv;
    return l;
  endfunction

  function automatic logic [4:0] phase_total(input op_state_t st);
    case (st)
      ST_START: return 5'd3;
      ST_STOP:  return 5'd3;
      ST_WRITE: return BIT_PHASES + 5'd1;
      ST_READ:  return BIT_PHASES + 5'd3;
      ST_WAIT:  return 5'd4;
      default:  return 5'd1;
    endcase
  endfunction

  task automatic load_phase();
    case (op_now)
      ST_START: begin
        if (step_no == 5'd0) lines = lv(1'b1, 1'b1, 1'b1);
        else if (step_no == 5'd1) lines = lv(1'b1, 1'b0, 1'b1);
        else lines = lv(1'b0, 1'b0, 1'b1);
      end
      ST_STOP: begin
        if (step_no == 5'd0) lines = lv(1'b0, 1'b0, 1'b1);
        else if (step_no == 5'd1) lines = lv(1'b1, 1'b0, 1'b1);
        else lines = lv(1'b1, 1'b1, 1'b1);
      end
      ST_WRITE: begin
        if (step_no < BIT_PHASES && !step_no[0]) lines = lv(1'b0, shreg[7], 1'b1);
        else if (step_no < BIT_PHASES) lines = lv(1'b1, lines.sda, 1'b1);
        else lines = lv(1'b0, lines.sda, 1'b1);
      end
      ST_READ: begin
        if (step_no < BIT_PHASES) lines = lv(step_no[0], 1'b1, 1'b0);
        else lines = lv(step_no == READ_ACK_PHASE, ~ack_flag, 1'b1);
      end
      ST_WAIT: begin
        if (step_no == 5'd0) lines = lv(1'b1, 1'b1, 1'b0);
        else if (step_no == 5'd1) lines = lv(1'b0, 1'b0, 1'b1);
        else if (step_no == 5'd2) lines = lv(1'b1, 1'b0, 1'b1);
        else lines = lv(1'b1, 1'b1, 1'b1);
      end
      default: ;
    endcase
  endtask

  task automatic advance_bus_tick(input in_item_t w, output out_item_t r);
    op_state_t   req;
    logic [15:0] span;
    logic [4:0]  p;
    logic        fin;
    r = '0;
    if (op_now == ST_IDLE && w.cmd_valid) begin
      case (w.operation)
        OP_CODE_START: req = ST_START;
        OP_CODE_STOP:  req = ST_STOP;
        OP_CODE_WRITE: req = ST_WRITE;
        OP_CODE_READ:  req = ST_READ;
        OP_CODE_WAIT:  req = ST_WAIT;
        default:       req = ST_IDLE;
      endcase
      if (req != ST_IDLE) begin
        op_now = req;
        step_no = '0;
        tick_no = '0;
        if (req == ST_WRITE) shreg = w.write_data;
        if (req == ST_READ) begin
          shreg = '0;
          ack_flag = w.send_ack;
        end
        if (req == ST_WAIT) ack_flag = 1'b0;
        load_phase();
        starts++;
      end
    end
    r.scl_level = lines.scl;
    r.sda_level = lines.sda;
    r.sda_drive = lines.drv;
    r.busy_res  = (op_now != ST_IDLE);
    if (op_now != ST_IDLE) begin
      span = (half_cfg == 16'd0) ? 16'd1 : half_cfg;
      tick_no = tick_no + 16'd1;
      if (tick_no >= span) begin
        p = step_no;
        fin = 1'b0;
        tick_no = '0;
        if (op_now == ST_READ && p < BIT_PHASES && p[0]) shreg = {shreg[6:0], w.sda_in};
        if (op_now == ST_WRITE && p < BIT_PHASES && p[0]) shreg = {shreg[6:0], 1'b0};
        if (op_now == ST_WAIT && p == 5'd0) begin
          if (!w.sda_in) begin
            fin = 1'b1;
            lines = lv(1'b0, 1'b1, 1'b0);
          end else begin
            ack_flag = 1'b1;
          end
        end
        if (!fin) begin
          step_no = step_no + 5'd1;
          if (step_no >= phase_total(op_now)) begin
            fin = 1'b1;
            if (op_now == ST_READ || op_now == ST_WAIT) lines = lv(1'b0, 1'b1, 1'b1);
          end else begin
            load_phase();
          end
        end
        if (fin) begin
          r.done_res = 1'b1;
          if (op_now == ST_READ) begin
            r.read_byte = shreg;
            reads++;
          end
          if (op_now == ST_WAIT) begin
            r.ack_missing = ack_flag;
            if (ack_flag) nacks++;
          end
          dones++;
          op_now = ST_IDLE;
          step_no = '0;
        end
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : monitor
    in_item_t  w;
    out_item_t want;
    out_item_t r;
    if (!rst_n) begin
      op_now   = ST_IDLE;
      step_no  = '0;
      tick_no  = '0;
      shreg    = '0;
      ack_flag = 1'b0;
      lines    = lv(1'b1, 1'b1, 1'b0);
      half_cfg = HALF_RESET;
      line_words_due.delete();
    end else begin
      if (cfg_we) half_cfg = cfg_wdata;
      if (out_mon.valid && out_mon.ready) begin
        if (line_words_due.size() == 0) begin
          $error("result word arrived with no expected word pending");
          errs++;
        end else begin
          want = line_words_due.pop_front();
          compare_field("scl_level", 8'(want.scl_level), 8'(out_mon.scl_level));
          compare_field("sda_level", 8'(want.sda_level), 8'(out_mon.sda_level));
          compare_field("sda_drive", 8'(want.sda_drive), 8'(out_mon.sda_drive));
          compare_field("busy_res", 8'(want.busy_res), 8'(out_mon.busy_res));
          compare_field("done_res", 8'(want.done_res), 8'(out_mon.done_res));
          compare_field("read_byte", want.read_byte, out_mon.read_byte);
          compare_field("ack_missing", 8'(want.ack_missing), 8'(out_mon.ack_missing));
          checked++;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        w.cmd_valid  = in_mon.cmd_valid;
        w.operation  = in_mon.operation;
        w.write_data = in_mon.write_data;
        w.send_ack   = in_mon.send_ack;
        w.sda_in     = in_mon.sda_in;
        advance_bus_tick(w, r);
        line_words_due.push_back(r);
      end
    end
    fail_count    <= errs;
    pending       <= line_words_due.size();
    started       <= starts;
    engine_busy   <= (op_now != ST_IDLE);
    words_checked <= checked;
    cmds_done     <= dones;
    reads_done    <= reads;
    nack_stops    <= nacks;
  end

endmodule

@@ sim/i2c_master_byte_engine_test.sv @@
// Testbench top for the I2C master byte engine: drives command and tick words,
// stalls the result channel and gives the verdict from the line checker.
// Depends on i2cm_pkg, the channel interfaces, the engine and i2cm_line_checker.
module i2c_master_byte_engine_test;
  import i2cm_pkg::*;

  localparam int         IDLE_LIMIT       = 2000;
  localparam int         RANDOM_WORDS     = 300;
  localparam logic [2:0] OP_CODE_LAST_BAD = 3'd7;
  localparam int         SDA_RANDOM       = 0;
  localparam int         SDA_LOW          = 1;
  localparam int         SDA_HIGH         = 2;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  bit          quiet;
  int          words_sent = 0;
  int          settings_used = 1;
  int          idle_cycles = 0;

  int   fail_count;
  int   pending;
  int   started;
  logic engine_busy;
  int   words_checked;
  int   cmds_done;
  int   reads_done;
  int   nack_stops;

  i2cm_in_if  in_bus();
  i2cm_out_if out_bus();

  i2c_master_byte_engine uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_bus    (in_bus),
    .out_bus   (out_bus)
  );

  i2cm_line_checker line_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_mon        (in_bus),
    .out_mon       (out_bus),
    .fail_count    (fail_count),
    .pending       (pending),
    .started       (started),
    .engine_busy   (engine_busy),
    .words_checked (words_checked),
    .cmds_done     (cmds_done),
    .reads_done    (reads_done),
    .nack_stops    (nack_stops)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && !((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))) begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("i2c_master_byte_engine verification failed");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (quiet || $urandom_range(0, 3) != 0) begin
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(10, 40))
          @(posedge clk);
        out_bus.ready <= 1'b1;
      end
    end
  end

  function automatic logic pick_sda(input int mode);
    if (mode == SDA_LOW) return 1'b0;
    if (mode == SDA_HIGH) return 1'b1;
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  task automatic send_word(input in_item_t w);
    int gap;
    in_bus.valid      <= 1'b1;
    in_bus.cmd_valid  <= w.cmd_valid;
    in_bus.operation  <= w.operation;
    in_bus.write_data <= w.write_data;
    in_bus.send_ack   <= w.send_ack;
    in_bus.sda_in     <= w.sda_in;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    words_sent++;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic idle_word(input int mode, input bit noise);
    in_item_t w;
    w = '0;
    w.sda_in     = pick_sda(mode);
    w.write_data = 8'($urandom);
    if (noise && $urandom_range(0, 7) == 0) begin
      w.cmd_valid = 1'b1;
      w.operation = 3'($urandom_range(0, 7));
      w.send_ack  = 1'($urandom_range(0, 1));
    end
    send_word(w);
  endtask

  task automatic offer_op(input logic [2:0] op);
    in_item_t w;
    w.cmd_valid  = 1'b1;
    w.operation  = op;
    w.write_data = 8'($urandom);
    w.send_ack   = 1'($urandom_range(0, 1));
    w.sda_in     = 1'($urandom_range(0, 1));
    send_word(w);
  endtask

  // The command is offered until the engine takes it. The copy that follows
  // is ignored while the engine is busy, or starts the command again when the
  // first one ended within a single tick.
  task automatic run_cmd(input logic [2:0] op, input logic [7:0] data, input logic ack,
                         input int mode, input bit noise);
    in_item_t w;
    int       base;
    base = started;
    w.cmd_valid  = 1'b1;
    w.operation  = op;
    w.write_data = data;
    w.send_ack   = ack;
    do begin
      w.sda_in = pick_sda(mode);
      send_word(w);
    end while (started == base);
    while (engine_busy) idle_word(mode, noise);
  endtask

  task automatic settle();
    bit again;
    do begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
      while (pending != 0) @(posedge clk);
      again = engine_busy;
      while (engine_busy) idle_word(SDA_RANDOM, 1'b0);
    end while (again);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_half(input logic [15:0] ticks);
    settle();
    cfg_wdata <= ticks;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  task automatic random_transaction();
    if ($urandom_range(0, 5) != 0) begin
      run_cmd(OP_CODE_START, 8'($urandom), 1'($urandom), SDA_RANDOM, 1'b1);
      repeat ($urandom_range(1, 2)) begin
        run_cmd(OP_CODE_WRITE, 8'($urandom), 1'($urandom), SDA_RANDOM, 1'b1);
        run_cmd(OP_CODE_WAIT, 8'($urandom), 1'($urandom), SDA_RANDOM, 1'b1);
      end
      if ($urandom_range(0, 1))
        repeat ($urandom_range(1, 2))
          run_cmd(OP_CODE_READ, 8'($urandom), 1'($urandom), SDA_RANDOM, 1'b1);
      run_cmd(OP_CODE_STOP, 8'($urandom), 1'($urandom), SDA_RANDOM, 1'b1);
    end else begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 3) == 0)
          offer_op(3'($urandom_range(OP_CODE_WAIT + 1, OP_CODE_LAST_BAD)));
        else run_cmd(3'($urandom_range(OP_CODE_START, OP_CODE_WAIT)), 8'($urandom),
                     1'($urandom), SDA_RANDOM, 1'b1);
      end
    end
    repeat ($urandom_range(0, 3)) idle_word(SDA_RANDOM, 1'b1);
  endtask

  initial begin
    int          mark;
    logic [15:0] half;
    logic [2:0]  bad;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_bus.valid      = 1'b0;
    in_bus.cmd_valid  = 1'b0;
    in_bus.operation  = OP_CODE_START;
    in_bus.write_data = '0;
    in_bus.send_ack   = 1'b0;
    in_bus.sda_in     = 1'b0;
    quiet             = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    run_cmd(OP_CODE_WAIT, 8'h00, 1'b0, SDA_LOW, 1'b0);

    set_half(16'd0);
    quiet = 1'b0;
    run_cmd(OP_CODE_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
    run_cmd(OP_CODE_WRITE, 8'hFF, 1'b0, SDA_RANDOM, 1'b0);
    run_cmd(OP_CODE_WAIT, 8'h00, 1'b0, SDA_LOW, 1'b0);
    run_cmd(OP_CODE_WRITE, 8'h00, 1'b1, SDA_RANDOM, 1'b0);
    run_cmd(OP_CODE_WAIT, 8'hFF, 1'b1, SDA_HIGH, 1'b0);
    run_cmd(OP_CODE_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
    run_cmd(OP_CODE_READ, 8'h00, 1'b1, SDA_HIGH, 1'b0);
    run_cmd(OP_CODE_READ, 8'hFF, 1'b0, SDA_LOW, 1'b0);
    run_cmd(OP_CODE_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
    settle();
    for (bad = OP_CODE_WAIT + 3'd1; bad != OP_CODE_START; bad++) offer_op(bad);
    run_cmd(OP_CODE_WRITE, 8'hA5, 1'b0, SDA_RANDOM, 1'b1);
    run_cmd(OP_CODE_READ, 8'h5A, 1'b1, SDA_RANDOM, 1'b1);

    mark = words_sent;
    while (words_sent - mark < RANDOM_WORDS) begin
      case ($urandom_range(0, 4))
        0:       half = 16'd0;
        1:       half = 16'd1;
        2:       half = 16'd2;
        3:       half = 16'd3;
        default: half = 16'($urandom_range(4, 8));
      endcase
      set_half(half);
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 6)) begin
        if (words_sent - mark < RANDOM_WORDS) begin
          random_transaction();
          if ($urandom_range(0, 2) == 0) settle();
        end
      end
    end

    set_half(16'd40);
    quiet = 1'b1;
    run_cmd(OP_CODE_START, 8'($urandom), 1'($urandom), SDA_RANDOM, 1'b0);
    set_half(16'd2);
    quiet = 1'b0;
    random_transaction();
    settle();

    $display("Checked %0d result words with %0d completed commands, %0d reads and %0d NACK stops.",
             words_checked, cmds_done, reads_done, nack_stops);
    $display("Used %0d half-period settings, from 0 and 1 up to the reset value of 250 ticks.",
             settings_used);
    if (fail_count == 0) begin
      $display("i2c_master_byte_engine verification clean");
    end else begin
      $display("i2c_master_byte_engine verification failed");
    end
    $finish;
  end

endmodule
